@@ rtl/gcrf_pkg.sv @@
// Shared types, register numbers and helpers for the geometry coprocessor register file.
package gcrf_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned WordCount  = 32;
   localparam int unsigned IndexWidth = $clog2(WordCount);
   localparam int unsigned ReqDataWidth = 40;

   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [IndexWidth-1:0] index_type;

   // Access kind carried in the request tuser
   typedef enum logic [1:0] {
      KIND_DATA_READ   = 2'd0,
      KIND_DATA_WRITE  = 2'd1,
      KIND_CTRL_READ   = 2'd2,
      KIND_CTRL_WRITE  = 2'd3
   } kind_type;

   // Data register numbers with special rules
   localparam index_type REG_VXY0  = 5'd1;
   localparam index_type REG_VXY1  = 5'd3;
   localparam index_type REG_VXY2  = 5'd5;
   localparam index_type REG_RES   = 5'd7;
   localparam index_type REG_IR0   = 5'd8;
   localparam index_type REG_IR1   = 5'd9;
   localparam index_type REG_IR2   = 5'd10;
   localparam index_type REG_IR3   = 5'd11;
   localparam index_type REG_SXY0  = 5'd12;
   localparam index_type REG_SXY1  = 5'd13;
   localparam index_type REG_SXY2  = 5'd14;
   localparam index_type REG_SXYP  = 5'd15;
   localparam index_type REG_RSV   = 5'd23;
   localparam index_type REG_IRGB  = 5'd28;
   localparam index_type REG_ORGB  = 5'd29;
   localparam index_type REG_LZCS  = 5'd30;
   localparam index_type REG_LZCR  = 5'd31;

   // Control register numbers that sign-extend on read
   localparam index_type CREG_H    = 5'd26;
   localparam index_type CREG_DQA  = 5'd27;
   localparam index_type CREG_ZSF3 = 5'd29;
   localparam index_type CREG_ZSF4 = 5'd30;

   // Force the upper half to ones when bit 15 is set
   function automatic word_type extend_low_half(input word_type w);
      word_type r;
      r = w;
      if (w[15]) begin
         r[31:16] = 16'hFFFF;
      end
      return r;
   endfunction

   // Count leading bits equal to the sign bit (1 to 32)
   function automatic logic [5:0] leading_sign_count(input word_type w);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 31; i++) begin
         if (w[i] != w[31]) begin
            n = 6'(31 - i);
         end
      end
      return n;
   endfunction

endpackage

@@ rtl/geometry_coprocessor_register_file_core.sv @@
// Geometry coprocessor register file: 32 data and 32 control words with special access rules.
// Reads: a read passes through the request register, then its result through the result register
//   onto rsp, where it is held longer under rsp stall.
// Throughput: one transaction per cycle unless a read meets rsp stall; each access is one pass
//   through the decode logic between the request and result registers, writes committing on it.
// Reset: synchronous, active high; clears all 64 words and both pipeline stage valid flags.
module geometry_coprocessor_register_file_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [4:0] reg_index, [36:5] write_value, [37] override, [39:38] zero
   input  logic [gcrf_pkg::ReqDataWidth-1:0]   req_tdata,
   // [1:0] kind
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] read_value
   output logic [gcrf_pkg::WordWidth-1:0]      rsp_tdata
);
   import gcrf_pkg::*;

   // Request register
   logic      s1_valid_ff, s1_valid_in;
   kind_type  s1_kind_ff;
   index_type s1_index_ff;
   word_type  s1_value_ff;
   logic      s1_override_ff;

   // Result register
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_data_ff, rsp_data_in;

   // Register banks
   word_type  data_ff [WordCount];
   word_type  data_in [WordCount];
   word_type  ctrl_ff [WordCount];
   word_type  ctrl_in [WordCount];

   logic      s1_is_read;
   logic      out_free;
   logic      s1_advance;
   word_type  read_value;

   // Handshake: the request stage moves on with a write, or with a read whose result has somewhere to go
   assign s1_is_read = (s1_kind_ff == KIND_DATA_READ) || (s1_kind_ff == KIND_CTRL_READ);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!s1_is_read || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_advance);

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_tvalid && req_tready) begin
         s1_kind_ff     <= kind_type'(req_tuser);
         s1_index_ff    <= req_tdata[IndexWidth-1:0];
         s1_value_ff    <= req_tdata[IndexWidth +: WordWidth];
         s1_override_ff <= req_tdata[IndexWidth + WordWidth];
      end
   end

   // Decode the read
   always_comb begin
      read_value = '0;
      if (s1_kind_ff == KIND_CTRL_READ) begin
         unique case (s1_index_ff) inside
            CREG_H, CREG_DQA, CREG_ZSF3, CREG_ZSF4:
               read_value = extend_low_half(ctrl_ff[s1_index_ff]);
            default:
               read_value = ctrl_ff[s1_index_ff];
         endcase
      end else begin
         unique case (s1_index_ff) inside
            REG_VXY0, REG_VXY1, REG_VXY2, REG_IR0, REG_IR1, REG_IR2, REG_IR3:
               read_value = extend_low_half(data_ff[s1_index_ff]);
            REG_RSV, REG_IRGB:
               read_value = '0;
            REG_ORGB:
               read_value = {17'd0, data_ff[REG_IR3][11:7], data_ff[REG_IR2][11:7],
                             data_ff[REG_IR1][11:7]};
            REG_LZCR:
               read_value = {26'd0, leading_sign_count(data_ff[REG_LZCS])};
            default:
               read_value = data_ff[s1_index_ff];
         endcase
      end
   end

   // Decode the write
   always_comb begin
      data_in = data_ff;
      ctrl_in = ctrl_ff;
      if (s1_advance) begin
         if (s1_kind_ff == KIND_CTRL_WRITE) begin
            ctrl_in[s1_index_ff] = s1_value_ff;
         end else if (s1_kind_ff == KIND_DATA_WRITE) begin
            if (s1_override_ff) begin
               data_in[s1_index_ff] = s1_value_ff;
            end else begin
               case (s1_index_ff) inside
                  REG_RES, REG_RSV, REG_ORGB, REG_LZCR: begin
                  end
                  REG_SXY2: begin
                     data_in[REG_SXY2] = s1_value_ff;
                     data_in[REG_SXYP] = s1_value_ff;
                  end
                  REG_SXYP: begin
                     data_in[REG_SXY0] = data_ff[REG_SXY1];
                     data_in[REG_SXY1] = data_ff[REG_SXY2];
                     data_in[REG_SXY2] = s1_value_ff;
                     data_in[REG_SXYP] = s1_value_ff;
                  end
                  REG_IRGB: begin
                     data_in[REG_IR1] = {20'd0, s1_value_ff[4:0], 7'd0};
                     data_in[REG_IR2] = {20'd0, s1_value_ff[9:5], 7'd0};
                     data_in[REG_IR3] = {20'd0, s1_value_ff[14:10], 7'd0};
                  end
                  default:
                     data_in[s1_index_ff] = s1_value_ff;
               endcase
            end
         end
      end
   end

   // Load the result register on a read, drain it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance && s1_is_read) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = read_value;
      end
   end

   // Commit banks and result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WordCount; i++) begin
            data_ff[i] <= '0;
            ctrl_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         data_ff      <= data_in;
         ctrl_ff      <= ctrl_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // A read leaving the request stage always lands in the result register
   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_is_read) |=> rsp_valid_ff)
      else $error("read left request stage without a result");

   // A write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !s1_is_read && out_free) |=> !rsp_valid_ff)
      else $error("write produced a result");

   // An empty request stage always takes a transaction
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty request stage not ready");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the geometry coprocessor register file core.
`timescale 1ns / 100ps

module tb;
   import gcrf_pkg::*;

   typedef struct {
      kind_type  kind;
      index_type index;
      word_type  value;
      logic      override;
   } access_item_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic [1:0]              req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [WordWidth-1:0]    rsp_tdata;

   access_item_type pending_accesses[$];
   access_item_type on_bus;
   word_type     expected_reads[$];
   word_type     data_model[WordCount];
   word_type     ctrl_model[WordCount];
   int unsigned  error_count = 0;
   int unsigned  req_idle_left = 0;
   int unsigned  req_calm_left = 0;
   int unsigned  rsp_stall_left = 0;
   int unsigned  rsp_calm_left = 0;

   index_type special_indices[] = '{REG_VXY0, REG_VXY1, REG_VXY2, REG_RES, REG_IR0,
      REG_IR1, REG_IR2, REG_IR3, REG_SXY0, REG_SXY1, REG_SXY2, REG_SXYP, REG_RSV,
      REG_IRGB, REG_ORGB, REG_LZCS, REG_LZCR, CREG_H, CREG_DQA};

   geometry_coprocessor_register_file_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock and reset
   initial begin
      fork
         forever #5 clock = ~clock;
      join_none
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Mostly no gap, some short ones, a few long; calm stretches have none
   function automatic int unsigned draw_gap(inout int unsigned calm_left);
      int unsigned roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic word_type sign_extend_half(input word_type w);
      return w[15] ? {16'hFFFF, w[15:0]} : w;
   endfunction

   // Number of leading bits equal to bit 31
   function automatic word_type sign_run_length(input word_type w);
      word_type n;
      n = 1;
      for (int i = 30; i >= 0; i--) begin
         if (w[i] != w[31]) break;
         n++;
      end
      return n;
   endfunction

   function automatic word_type data_read_value(input index_type idx);
      case (idx)
         REG_VXY0, REG_VXY1, REG_VXY2, REG_IR0, REG_IR1, REG_IR2, REG_IR3: begin
            return sign_extend_half(data_model[idx]);
         end
         REG_RSV, REG_IRGB: return '0;
         REG_ORGB: begin
            return {17'b0, data_model[REG_IR3][11:7], data_model[REG_IR2][11:7],
                    data_model[REG_IR1][11:7]};
         end
         REG_LZCR: return sign_run_length(data_model[REG_LZCS]);
         default: return data_model[idx];
      endcase
   endfunction

   function automatic word_type ctrl_read_value(input index_type idx);
      case (idx)
         CREG_H, CREG_DQA, CREG_ZSF3, CREG_ZSF4: return sign_extend_half(ctrl_model[idx]);
         default: return ctrl_model[idx];
      endcase
   endfunction

   // Apply one accepted access to the shadow banks and queue any read result
   task automatic apply_access(input access_item_type a);
      case (a.kind)
         KIND_DATA_READ:  expected_reads.push_back(data_read_value(a.index));
         KIND_CTRL_READ:  expected_reads.push_back(ctrl_read_value(a.index));
         KIND_CTRL_WRITE: ctrl_model[a.index] = a.value;
         default: begin
            if (a.override) begin
               data_model[a.index] = a.value;
            end else begin
               case (a.index)
                  REG_RES, REG_RSV, REG_ORGB, REG_LZCR: ;
                  REG_SXY2: begin
                     data_model[REG_SXY2] = a.value;
                     data_model[REG_SXYP] = a.value;
                  end
                  REG_SXYP: begin
                     data_model[REG_SXY0] = data_model[REG_SXY1];
                     data_model[REG_SXY1] = data_model[REG_SXY2];
                     data_model[REG_SXY2] = a.value;
                     data_model[REG_SXYP] = a.value;
                  end
                  REG_IRGB: begin
                     data_model[REG_IR1] = {20'b0, a.value[4:0], 7'b0};
                     data_model[REG_IR2] = {20'b0, a.value[9:5], 7'b0};
                     data_model[REG_IR3] = {20'b0, a.value[14:10], 7'b0};
                  end
                  default: data_model[a.index] = a.value;
               endcase
            end
         end
      endcase
   endtask

   task automatic queue_access(input kind_type kind, input index_type idx,
                               input word_type value, input logic override);
      access_item_type a;
      a.kind = kind;
      a.index = idx;
      a.value = value;
      a.override = override;
      pending_accesses.push_back(a);
   endtask

   function automatic word_type random_word();
      word_type w;
      case ($urandom_range(0, 4))
         0: w = $urandom;
         1: w = ($urandom_range(0, 1) ? '1 : '0) ^ ($urandom >> $urandom_range(0, 31));
         2: w = $urandom_range(0, 16'hFFFF);
         3: begin
            case ($urandom_range(0, 3))
               0: w = '0;
               1: w = '1;
               2: w = 32'h8000_0000;
               default: w = 32'h7FFF_FFFF;
            endcase
         end
         default: w = {16'($urandom_range(0, 16'hFFFF)), 1'b1, 15'($urandom)};
      endcase
      return w;
   endfunction

   // Request driver: present queued accesses with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_access(on_bus);
         end
         if (!req_tvalid || req_tready) begin
            if (req_idle_left > 0) begin
               req_idle_left--;
               req_tvalid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
               on_bus = pending_accesses.pop_front();
               req_tdata <= {2'b00, on_bus.override, on_bus.value, on_bus.index};
               req_tuser <= on_bus.kind;
               req_tvalid <= 1'b1;
               req_idle_left = draw_gap(req_calm_left);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: random stalls on rsp_tready
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall_left = draw_gap(rsp_calm_left);
      end
   end

   // Monitor: compare each result transaction with the oldest expected read
   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reads.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = expected_reads.pop_front();
            if (rsp_tdata !== want) begin
               report_mismatch($sformatf("read_value %h, expected %h", rsp_tdata, want));
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      access_item_type a;
      for (int i = 0; i < WordCount; i++) begin
         data_model[i] = '0;
         ctrl_model[i] = '0;
      end

      // Reads after reset, sign extension with bit 15 set and clear
      queue_access(KIND_DATA_READ, REG_LZCR, '0, 1'b0);
      queue_access(KIND_DATA_WRITE, REG_VXY0, 32'h0000_8000, 1'b0);
      queue_access(KIND_DATA_READ, REG_VXY0, '0, 1'b0);
      queue_access(KIND_DATA_WRITE, REG_VXY1, 32'h1234_7FFF, 1'b0);
      queue_access(KIND_DATA_READ, REG_VXY1, '0, 1'b0);
      // Colour unpack then pack; zero reads
      queue_access(KIND_DATA_WRITE, REG_IRGB, 32'hFFFF_FFFF, 1'b0);
      queue_access(KIND_DATA_READ, REG_ORGB, '0, 1'b0);
      queue_access(KIND_DATA_READ, REG_IRGB, '0, 1'b0);
      queue_access(KIND_DATA_READ, REG_IR3, '0, 1'b0);
      // Mirror and screen-coordinate queue push
      queue_access(KIND_DATA_WRITE, REG_SXY2, 32'h8000_0000, 1'b0);
      queue_access(KIND_DATA_WRITE, REG_SXYP, 32'h7FFF_FFFF, 1'b0);
      queue_access(KIND_DATA_WRITE, REG_SXYP, 32'h0000_0001, 1'b0);
      queue_access(KIND_DATA_READ, REG_SXY0, '0, 1'b0);
      queue_access(KIND_DATA_READ, REG_SXY1, '0, 1'b0);
      queue_access(KIND_DATA_READ, REG_SXYP, '0, 1'b0);
      // Ignored write, then the same with override
      queue_access(KIND_DATA_WRITE, REG_RES, 32'h0000_0005, 1'b0);
      queue_access(KIND_DATA_WRITE, REG_RSV, 32'hFFFF_FFFF, 1'b1);
      queue_access(KIND_DATA_READ, REG_RSV, '0, 1'b0);
      queue_access(KIND_DATA_WRITE, REG_RES, 32'hFFFF_FFFF, 1'b1);
      queue_access(KIND_DATA_READ, REG_RES, '0, 1'b0);
      // Leading count at the top of its range and just below it
      queue_access(KIND_DATA_WRITE, REG_LZCS, 32'h0000_0001, 1'b0);
      queue_access(KIND_DATA_READ, REG_LZCR, '0, 1'b0);
      queue_access(KIND_DATA_WRITE, REG_LZCS, 32'hFFFF_FFFF, 1'b0);
      queue_access(KIND_DATA_READ, REG_LZCR, '0, 1'b0);
      // Control bank with sign extension
      queue_access(KIND_CTRL_WRITE, CREG_H, 32'h0000_8001, 1'b0);
      queue_access(KIND_CTRL_READ, CREG_H, '0, 1'b0);

      // Random accesses, biased toward the registers with special rules
      repeat (1950) begin
         a.kind = kind_type'($urandom_range(0, 3));
         if ($urandom_range(0, 1))
            a.index = special_indices[$urandom_range(0, special_indices.size() - 1)];
         else
            a.index = index_type'($urandom_range(0, WordCount - 1));
         a.value = random_word();
         a.override = ($urandom_range(0, 99) < 15);
         pending_accesses.push_back(a);
      end

      // Drain: wait for all requests and results, then let the pipeline settle
      @(negedge reset);
      while (pending_accesses.size() != 0 || req_tvalid || expected_reads.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/gcrf_pkg.sv
rtl/geometry_coprocessor_register_file_core.sv
bench/tb.sv
